FILE: rtl/core/entity_id_allocator_with_masks_assert.svh
// Assertion macros shared by the allocator RTL.
// Each macro checks a property on the rising edge of clk.
// The first form is disabled while rst is high. The second form is always active.
`ifndef ENTITY_ID_ALLOCATOR_WITH_MASKS_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_WITH_MASKS_ASSERT_SVH
`ifndef SYNTHESIS
`define EIDA_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator check failed");
`define EIDA_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");
`else
`define EIDA_CHECK(lbl, prop)
`define EIDA_CHECK_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/eida_pkg.sv
package eida_pkg;

  // Default sizing.
  localparam int MAX_ENTITIES_DEF    = 256;
  localparam int COMPONENT_TYPES_DEF = 32;

  // Fixed field widths of the transaction ports.
  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int COMP_W   = 5;
  localparam int STATUS_W = 3;
  localparam int MASK_W   = 32;
  localparam int COUNT_W  = 9;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_CHANGED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAME    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUERY   = 3'd4;

  // A classified command as it sits in the queue.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entity_id;
    logic [COMP_W-1:0] comp_idx;
    logic              in_range;
    logic              comp_ok;
  } cmd_t;

endpackage

FILE: rtl/core/eida_front.sv
module eida_front #(
  parameter int MAX_ENTITIES    = eida_pkg::MAX_ENTITIES_DEF,
  parameter int COMPONENT_TYPES = eida_pkg::COMPONENT_TYPES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  logic [eida_pkg::KIND_W-1:0] kind,
  input  logic [eida_pkg::ID_W-1:0]   entity_id,
  input  logic [eida_pkg::COMP_W-1:0] component_index,
  output logic                        head_valid,
  output eida_pkg::cmd_t              head,
  input  logic                        pop
);

  eida_pkg::cmd_t                   slots [eida_pkg::QUEUE_DEPTH];
  logic [eida_pkg::QPTR_W-1:0]      wr_ptr;
  logic [eida_pkg::QPTR_W-1:0]      rd_ptr;
  logic [eida_pkg::QCNT_W-1:0]      count;
  eida_pkg::cmd_t                   incoming;
  logic                             push;
  logic                             do_pop;

  // Classify the entering command: range of the ID and of the component bit.
  always_comb begin
    incoming.kind      = kind;
    incoming.entity_id = entity_id;
    incoming.comp_idx  = component_index;
    incoming.in_range  = ({24'd0, entity_id} < 32'(MAX_ENTITIES));
    incoming.comp_ok   = ({27'd0, component_index} < 32'(COMPONENT_TYPES));
  end

  assign cmd_stall  = (count == eida_pkg::QCNT_W'(eida_pkg::QUEUE_DEPTH));
  assign push       = cmd_valid && !cmd_stall;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == eida_pkg::QPTR_W'(eida_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == eida_pkg::QPTR_W'(eida_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/eida_back.sv
`include "entity_id_allocator_with_masks_assert.svh"

module eida_back #(
  parameter int MAX_ENTITIES    = eida_pkg::MAX_ENTITIES_DEF,
  parameter int COMPONENT_TYPES = eida_pkg::COMPONENT_TYPES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  eida_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [eida_pkg::ID_W-1:0]     result_id,
  output logic [eida_pkg::STATUS_W-1:0] status,
  output logic                          exists,
  output logic [eida_pkg::MASK_W-1:0]   component_mask,
  output logic [eida_pkg::COUNT_W-1:0]  live_count
);

  localparam int IDW = $clog2(MAX_ENTITIES);
  localparam int CW  = $clog2(MAX_ENTITIES + 1);
  localparam int MW  = COMPONENT_TYPES;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTITIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Entity word: live flag on top, component mask below.
  logic [IDW-1:0] free_stack [MAX_ENTITIES];
  logic [MW:0]    ent_mem    [MAX_ENTITIES];

  logic           state;
  eida_pkg::cmd_t cur;
  logic [IDW-1:0] stack_q;
  logic [MW:0]    ent_q;
  logic [CW-1:0]  stack_depth;
  logic [CW-1:0]  fresh_next;
  logic [CW-1:0]  live_total;

  logic [CW-1:0]  depth_m1;
  logic [IDW-1:0] rd_idx;
  logic [IDW-1:0] head_id;
  logic [IDW-1:0] cur_id;
  logic [CW-1:0]  cur_id_cw;
  logic [IDW+eida_pkg::ID_W-1:0] head_wide;
  logic [IDW+eida_pkg::ID_W-1:0] cur_wide;
  logic [CW+IDW-1:0]             cur_id_wide;
  logic [MW+31:0]                bit_wide;
  logic [MW-1:0]                 bit_v;
  logic                          live;
  logic [MW-1:0]                 mask;
  logic                          out_free;
  logic                          fire;

  logic [IDW-1:0]                res_id;
  logic [eida_pkg::STATUS_W-1:0] res_status;
  logic                          res_exists;
  logic [MW-1:0]                 res_mask;
  logic                          ent_wr;
  logic [IDW-1:0]                ent_wr_addr;
  logic [MW:0]                   ent_wr_data;
  logic                          stack_push;
  logic                          use_cmd_id;
  logic [CW-1:0]                 stack_depth_next;
  logic [CW-1:0]                 fresh_next_next;
  logic [CW-1:0]                 live_total_next;
  logic [IDW+eida_pkg::ID_W-1:0] res_id_wide;
  logic [MW+eida_pkg::MASK_W-1:0] res_mask_wide;
  logic [CW+eida_pkg::COUNT_W-1:0] live_wide;

  assign depth_m1    = stack_depth - 1'b1;
  assign rd_idx      = depth_m1[IDW-1:0];
  assign head_wide   = {{IDW{1'b0}}, head.entity_id};
  assign head_id     = head_wide[IDW-1:0];
  assign cur_wide    = {{IDW{1'b0}}, cur.entity_id};
  assign cur_id      = cur_wide[IDW-1:0];
  assign cur_id_wide = {{CW{1'b0}}, cur_id};
  assign cur_id_cw   = cur_id_wide[CW-1:0];
  assign bit_wide    = {{(MW+31){1'b0}}, 1'b1} << cur.comp_idx;
  assign bit_v       = bit_wide[MW-1:0] & {MW{cur.comp_ok}};

  // Entries at or above the fresh pointer were never written and read as dead.
  assign live = cur.in_range && (cur_id_cw < fresh_next) && ent_q[MW];
  assign mask = ent_q[MW-1:0];

  assign out_free = !rsp_valid || !rsp_stall;
  assign fire     = (state == ST_EXEC) && out_free;
  assign pop      = (state == ST_IDLE) && head_valid;

  always_comb begin
    res_id           = cur_id;
    use_cmd_id       = 1'b1;
    res_status       = eida_pkg::ST_SAME;
    res_exists       = live;
    res_mask         = live ? mask : '0;
    ent_wr           = 1'b0;
    ent_wr_addr      = cur_id;
    ent_wr_data      = '0;
    stack_push       = 1'b0;
    stack_depth_next = stack_depth;
    fresh_next_next  = fresh_next;
    live_total_next  = live_total;
    case (cur.kind)
      eida_pkg::KIND_CREATE: begin
        use_cmd_id = 1'b0;
        res_exists = 1'b1;
        res_mask   = '0;
        res_status = eida_pkg::ST_CHANGED;
        if (stack_depth != '0) begin
          res_id           = stack_q;
          stack_depth_next = depth_m1;
        end else if (fresh_next < MAX_CW) begin
          res_id          = fresh_next[IDW-1:0];
          fresh_next_next = fresh_next + 1'b1;
        end else begin
          res_id     = '0;
          res_status = eida_pkg::ST_FULL;
          res_exists = 1'b0;
        end
        if (res_status == eida_pkg::ST_CHANGED) begin
          ent_wr          = 1'b1;
          ent_wr_addr     = res_id;
          ent_wr_data     = {1'b1, {MW{1'b0}}};
          live_total_next = live_total + 1'b1;
        end
      end
      eida_pkg::KIND_QUERY: begin
        res_status = eida_pkg::ST_QUERY;
      end
      eida_pkg::KIND_REMOVE: begin
        if (!live) begin
          res_status = eida_pkg::ST_NONE;
        end else begin
          res_status      = eida_pkg::ST_CHANGED;
          res_exists      = 1'b0;
          res_mask        = '0;
          ent_wr          = 1'b1;
          ent_wr_data     = '0;
          live_total_next = live_total - 1'b1;
          if (stack_depth < MAX_CW) begin
            stack_push       = 1'b1;
            stack_depth_next = stack_depth + 1'b1;
          end
        end
      end
      eida_pkg::KIND_ATTACH: begin
        if (!live) begin
          res_status = eida_pkg::ST_NONE;
        end else if ((mask & bit_v) == '0 && bit_v != '0) begin
          res_status  = eida_pkg::ST_CHANGED;
          res_mask    = mask | bit_v;
          ent_wr      = 1'b1;
          ent_wr_data = {1'b1, mask | bit_v};
        end
      end
      eida_pkg::KIND_DETACH: begin
        if (!live) begin
          res_status = eida_pkg::ST_NONE;
        end else if ((mask & bit_v) != '0) begin
          res_status  = eida_pkg::ST_CHANGED;
          res_mask    = mask & ~bit_v;
          ent_wr      = 1'b1;
          ent_wr_data = {1'b1, mask & ~bit_v};
        end
      end
      default: begin
        res_status = eida_pkg::ST_SAME;
      end
    endcase
  end

  assign res_id_wide   = {{eida_pkg::ID_W{1'b0}}, res_id};
  assign res_mask_wide = {{eida_pkg::MASK_W{1'b0}}, res_mask};
  assign live_wide     = {{eida_pkg::COUNT_W{1'b0}}, live_total_next};

  // Memories: reads only at pop, writes only at fire, never in the same cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      stack_q <= free_stack[rd_idx];
      ent_q   <= ent_mem[head_id];
      cur     <= head;
    end
    if (fire && ent_wr) begin
      ent_mem[ent_wr_addr] <= ent_wr_data;
    end
    if (fire && stack_push) begin
      free_stack[stack_depth[IDW-1:0]] <= cur_id;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_id      <= use_cmd_id ? cur.entity_id : res_id_wide[eida_pkg::ID_W-1:0];
      status         <= res_status;
      exists         <= res_exists;
      component_mask <= res_mask_wide[eida_pkg::MASK_W-1:0];
      live_count     <= live_wide[eida_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      stack_depth <= '0;
      fresh_next  <= '0;
      live_total  <= '0;
    end else begin
      if (fire) begin
        rsp_valid   <= 1'b1;
        stack_depth <= stack_depth_next;
        fresh_next  <= fresh_next_next;
        live_total  <= live_total_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (pop) begin
        state <= ST_EXEC;
      end else if (fire) begin
        state <= ST_IDLE;
      end
    end
  end

  // Every ID handed out so far is either live or waiting on the free stack.
  `EIDA_CHECK(a_id_conservation, ({1'b0, live_total} + {1'b0, stack_depth}) == {1'b0, fresh_next})
  // A command taken from the queue puts the back end into its execute state in the following cycle.
  `EIDA_CHECK(a_pop_then_exec, pop |=> (state == ST_EXEC))
  // A full answer is only given when both ID sources are exhausted.
  `EIDA_CHECK(a_full_exhausted, (rsp_valid && status == eida_pkg::ST_FULL) |-> ((stack_depth == '0) && (fresh_next == MAX_CW)))

endmodule

FILE: rtl/core/entity_id_allocator_with_masks.sv
// A command passes the queue, the memory read, then the update that loads its result.
// The back end takes a new command only after the update of the last one.
// A two-entry command queue lets new transactions enter while a result waits to be taken.
// Reset (rst, synchronous, active high) empties the queue and the result register.
// It also clears the live count, the free stack depth and the fresh ID pointer.
// No clearing pass over the entity memory is needed after reset.
module entity_id_allocator_with_masks #(
  parameter int MAX_ENTITIES    = eida_pkg::MAX_ENTITIES_DEF,
  parameter int COMPONENT_TYPES = eida_pkg::COMPONENT_TYPES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [eida_pkg::KIND_W-1:0]   kind,
  input  logic [eida_pkg::ID_W-1:0]     entity_id,
  input  logic [eida_pkg::COMP_W-1:0]   component_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [eida_pkg::ID_W-1:0]     result_id,
  output logic [eida_pkg::STATUS_W-1:0] status,
  output logic                          exists,
  output logic [eida_pkg::MASK_W-1:0]   component_mask,
  output logic [eida_pkg::COUNT_W-1:0]  live_count
);

  // The front end checks whether the entity ID is in range.
  // It also checks whether the component bit is one the design implements.
  // It then queues the classified command. The back end takes one command at a time.
  // When it takes a command it reads the free stack top and the addressed entity word.
  // In the execute state it applies the update and loads the result register.
  // It waits in the execute state while the previous result is still stalled.
  eida_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  eida_front #(
    .MAX_ENTITIES    (MAX_ENTITIES),
    .COMPONENT_TYPES (COMPONENT_TYPES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .kind            (kind),
    .entity_id       (entity_id),
    .component_index (component_index),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop)
  );

  // Liveness is kept in the entity memory itself.
  // An entry is trusted only below the fresh ID pointer.
  // Every entry below that pointer has been written by a create.
  eida_back #(
    .MAX_ENTITIES    (MAX_ENTITIES),
    .COMPONENT_TYPES (COMPONENT_TYPES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_id      (result_id),
    .status         (status),
    .exists         (exists),
    .component_mask (component_mask),
    .live_count     (live_count)
  );

endmodule
